@@ rtl/core/pttr_pkg.sv @@
// Shared types, constants and helper functions for the palette texture expander.
`timescale 1ns / 1ps

package pttr_pkg;

  // Input item kinds
  localparam logic MODE_PALETTE_WRITE = 1'b0;
  localparam logic MODE_PIXEL_BYTE    = 1'b1;

  // Color depth register values
  localparam logic DEPTH_4BPP = 1'b0;
  localparam logic DEPTH_8BPP = 1'b1;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_COLOR_DEPTH_MODE = 2'd0;
  localparam logic [1:0] REG_TEXTURE_WIDTH    = 2'd1;
  localparam logic [1:0] REG_TEXTURE_HEIGHT   = 2'd2;

  // Register reset values
  localparam logic        RESET_COLOR_DEPTH = DEPTH_8BPP;
  localparam logic [15:0] RESET_WIDTH       = 16'd256;
  localparam logic [15:0] RESET_HEIGHT      = 16'd256;

  // Raw alpha at or above this saturates to full opacity
  localparam logic [7:0] ALPHA_SAT = 8'h7F;

  // Op queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic        color_depth_mode;
    logic [15:0] texture_width;
    logic [15:0] texture_height;
  } cfg_t;

  // One queued op: a palette write or one visible pixel lookup
  typedef struct packed {
    logic        is_write;
    logic [7:0]  idx;
    logic [31:0] data;       // {alpha, blue, green, red}
    logic        item_last;
    logic        frame_last;
  } op_t;

  function automatic logic [7:0] expand_alpha(input logic [7:0] a);
    logic [7:0] r;
    if (a >= ALPHA_SAT) begin
      r = 8'hFF;
    end else if (a == 8'd0) begin
      r = 8'd0;
    end else begin
      r = {a[6:0] + 7'd1, 1'b0};
    end
    return r;
  endfunction

  function automatic logic [7:0] swap_bits_3_4(input logic [7:0] p);
    return {p[7:5], p[3], p[4], p[2:0]};
  endfunction

endpackage

@@ rtl/core/pttr_front.sv @@
// Front end: accepts items, steps the row/column counters and emits palette write and visible pixel ops.
`timescale 1ns / 1ps

module pttr_front (
  input  logic           clk,
  input  logic           rst,
  input  pttr_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           mode,
  input  logic [7:0]     entry_position,
  input  logic [7:0]     red_in,
  input  logic [7:0]     green_in,
  input  logic [7:0]     blue_in,
  input  logic [7:0]     alpha_in,
  input  logic [7:0]     pixel_byte,
  output logic           push,
  output pttr_pkg::op_t  push_op,
  input  logic           q_full
);
  import pttr_pkg::*;

  logic [15:0] column_count;
  logic [15:0] row_count;
  logic        pending;
  logic [3:0]  pend_nib;

  logic        take_in;
  logic        do_pend;
  logic        pix_step;
  logic        depth8;
  logic [16:0] aligned;
  logic [15:0] rows;
  logic [16:0] col_inc;
  logic [16:0] row_inc;
  logic        wrap;
  logic [15:0] col_adv;
  logic [15:0] row_adv;
  logic        vis;
  logic        vis_next;
  logic        frame_l;
  logic [7:0]  pix_idx;
  logic        pix_last;

  assign depth8   = (cfg.color_depth_mode == DEPTH_8BPP);
  assign in_ready = !pending && !q_full;
  assign take_in  = in_valid && in_ready;
  assign do_pend  = pending && !q_full;
  assign pix_step = (take_in && (mode == MODE_PIXEL_BYTE)) || do_pend;

  // padded row length, at least one group of 8
  assign aligned = (cfg.texture_width == 16'd0) ? 17'd8
                 : (({1'b0, cfg.texture_width} + 17'd7) & ~17'd7);
  assign rows    = (cfg.texture_height == 16'd0) ? 16'd1 : cfg.texture_height;

  assign col_inc = {1'b0, column_count} + 17'd1;
  assign row_inc = {1'b0, row_count} + 17'd1;
  assign wrap    = (col_inc >= aligned);
  assign col_adv = wrap ? 16'd0 : col_inc[15:0];
  always_comb begin
    row_adv = row_count;
    if (wrap) begin
      row_adv = (row_inc >= {1'b0, rows}) ? 16'd0 : row_inc[15:0];
    end
  end

  assign vis      = (column_count < cfg.texture_width);
  assign vis_next = (col_adv < cfg.texture_width);
  assign frame_l  = (col_inc == {1'b0, cfg.texture_width}) && (row_inc >= {1'b0, rows});

  always_comb begin
    if (do_pend) begin
      pix_idx  = {4'd0, pend_nib};
      pix_last = 1'b1;
    end else if (depth8) begin
      pix_idx  = pixel_byte;
      pix_last = 1'b1;
    end else begin
      pix_idx  = {4'd0, pixel_byte[3:0]};
      pix_last = !vis_next;   // high nibble will be padding
    end
  end

  always_comb begin
    push_op = '0;
    if (take_in && (mode == MODE_PALETTE_WRITE)) begin
      push_op.is_write = 1'b1;
      push_op.idx      = depth8 ? swap_bits_3_4(entry_position) : entry_position;
      push_op.data     = {expand_alpha(alpha_in), blue_in, green_in, red_in};
    end else begin
      push_op.idx        = pix_idx;
      push_op.item_last  = pix_last;
      push_op.frame_last = frame_l;
    end
  end

  assign push = (take_in && (mode == MODE_PALETTE_WRITE)) || (pix_step && vis);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      pending      <= 1'b0;
    end else begin
      if (take_in && (mode == MODE_PALETTE_WRITE)) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (pix_step) begin
        column_count <= col_adv;
        row_count    <= row_adv;
      end
      if (do_pend) begin
        pending <= 1'b0;
      end else if (take_in && (mode == MODE_PIXEL_BYTE) && !depth8) begin
        pending <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      pend_nib <= pixel_byte[7:4];
    end
  end

endmodule

@@ rtl/core/pttr_queue.sv @@
// Small op queue decoupling the front end from the palette back end.
`timescale 1ns / 1ps

module pttr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pttr_pkg::op_t push_op,
  output logic          full,
  output logic          head_valid,
  output pttr_pkg::op_t head_op,
  input  logic          pop
);
  import pttr_pkg::*;

  op_t               slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/pttr_back.sv @@
// Back end: palette memory, registered lookup and the output register.
`timescale 1ns / 1ps

module pttr_back #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  pttr_pkg::op_t head_op,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    red_out,
  output logic [7:0]    green_out,
  output logic [7:0]    blue_out,
  output logic [7:0]    alpha_out,
  output logic          item_last,
  output logic          frame_last
);
  import pttr_pkg::*;

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [31:0]   palette_store [PALETTE_DEPTH];
  logic [31:0]   rdata;
  logic [AW-1:0] addr;
  logic          in_range;
  logic          rd_en;
  logic          advance;

  logic s1_valid;
  logic s1_in_range;
  logic s1_item_last;
  logic s1_frame_last;

  assign addr     = head_op.idx[AW-1:0];
  assign in_range = ({1'b0, head_op.idx} < 9'(PALETTE_DEPTH));
  assign advance  = !out_valid || out_ready;
  // writes never wait on the output; lookups need room in the read stage
  assign pop      = head_valid && (head_op.is_write || !s1_valid || advance);
  assign rd_en    = pop && !head_op.is_write;

  always_ff @(posedge clk) begin
    if (pop && head_op.is_write && in_range) begin
      palette_store[addr] <= head_op.data;
    end
    if (rd_en) begin
      rdata <= palette_store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!s1_valid || advance) begin
        s1_valid <= rd_en;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_in_range   <= in_range;
      s1_item_last  <= head_op.item_last;
      s1_frame_last <= head_op.frame_last;
    end
    if (advance && s1_valid) begin
      {alpha_out, blue_out, green_out, red_out} <= s1_in_range ? rdata : 32'd0;
      item_last  <= s1_item_last;
      frame_last <= s1_frame_last;
    end
  end

endmodule

@@ rtl/core/palette_texture_to_rgba.sv @@
// Top level of the indexed texture to RGBA expander.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready): each beat is either a palette write
//   (mode 0: entry_position plus raw RGBA) or a packed pixel byte (mode 1).
//   Output channel (out_valid/out_ready): one beat per visible pixel, with
//   item_last on the last pixel of a byte and frame_last on the final
//   visible pixel of the frame. Padding pixels produce no beat.
//   Config channel (cfg_valid/cfg_ready): cfg_index selects depth mode (0),
//   width (1) or height (2); always ready; write only while idle.
//   Path: a pixel op passes the op queue, the registered palette read
//   and the output register. Throughput: the front end steps one pixel
//   per cycle while the queue has room, so an 8bpp byte can be taken
//   every cycle; a 4bpp byte keeps in_ready low for its high nibble.
//   Palette writes go through the same op queue, so they land in order
//   with the lookups around them.
//   Reset: counters, queue and output clear; registers return to 8bpp,
//   256 x 256. Palette contents stay undefined until written.
//   Receiver stall: the output register holds, the read stage and the
//   4-entry op queue fill, then in_ready drops.

module palette_texture_to_rgba #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  entry_position,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  input  logic [7:0]  pixel_byte,
  // output channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [7:0]  alpha_out,
  output logic        item_last,
  output logic        frame_last
);
  import pttr_pkg::*;

  cfg_t cfg;
  logic push;
  op_t  push_op;
  logic q_full;
  logic head_valid;
  op_t  head_op;
  logic pop;

  // config registers; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_depth_mode <= RESET_COLOR_DEPTH;
      cfg.texture_width    <= RESET_WIDTH;
      cfg.texture_height   <= RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLOR_DEPTH_MODE: cfg.color_depth_mode <= cfg_data[0];
        REG_TEXTURE_WIDTH:    cfg.texture_width    <= cfg_data;
        REG_TEXTURE_HEIGHT:   cfg.texture_height   <= cfg_data;
        default:              cfg <= cfg;
      endcase
    end
  end

  pttr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .entry_position (entry_position),
    .red_in         (red_in),
    .green_in       (green_in),
    .blue_in        (blue_in),
    .alpha_in       (alpha_in),
    .pixel_byte     (pixel_byte),
    .push           (push),
    .push_op        (push_op),
    .q_full         (q_full)
  );

  pttr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop)
  );

  pttr_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_op    (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .alpha_out  (alpha_out),
    .item_last  (item_last),
    .frame_last (frame_last)
  );

endmodule

@@ rtl/core/pttr_checker.sv @@
// Port-level checks for the palette texture expander, bound to the top level.
`timescale 1ns / 1ps

module pttr_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_ready,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [7:0] alpha_out,
  input logic       item_last,
  input logic       frame_last
);

  // stalled output beat holds valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid &&
      $stable({red_out, green_out, blue_out, alpha_out, item_last, frame_last}))
    else $error("output beat changed while stalled");

  // nothing pending right after reset
  a_reset_out: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // empty queue after reset: input side ready
  a_reset_in: assert property (@(posedge clk) $past(rst) |-> in_ready)
    else $error("input not ready right after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind palette_texture_to_rgba pttr_checker u_pttr_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_ready  (cfg_ready),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .red_out    (red_out),
  .green_out  (green_out),
  .blue_out   (blue_out),
  .alpha_out  (alpha_out),
  .item_last  (item_last),
  .frame_last (frame_last)
);
